// ===== rtl/rtp_video_reorder_start_gate_core_defines.svh =====
// ---------------------------------------------------------------------------
// rtp video reorder start gate - assertion macros
// shared concurrent assertion forms, clocked on clock, off during reset
// ---------------------------------------------------------------------------
`ifndef RTP_VIDEO_REORDER_START_GATE_CORE_DEFINES_SVH
`define RTP_VIDEO_REORDER_START_GATE_CORE_DEFINES_SVH

// expression holds at every edge out of reset
`define RVSG_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// antecedent implies consequent on the following edge
`define RVSG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rvsg_pkg.sv =====
// ---------------------------------------------------------------------------
// rvsg_pkg
// types, codes and constants of the rtp video reorder start gate
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rvsg_pkg;

   localparam int BufferDepthDefault = 32;
   localparam int MaxResults         = 32;
   localparam logic [15:0] ModeBcBit = 16'h8000;
   localparam logic [15:0] PictBit   = 16'h0010;

   typedef enum logic [1:0] {
      FUNC_PACKET  = 2'd0,
      FUNC_TICK    = 2'd1,
      FUNC_FLUSH   = 2'd2,
      FUNC_RESTART = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_ACCEPTED = 2'd0,
      ST_DUPLICATE = 2'd1,
      ST_INVALID = 2'd2,
      ST_FULL = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SEL_STATUS = 2'd0,
      SEL_EMPTY  = 2'd1,
      SEL_FLUSH  = 2'd2
   } rsp_sel_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_SRCH_CHK, S_SRCH_RD, S_SRCH_CMP, S_GATE, S_STORE_CHK,
      S_SHF_CHK, S_SHF_RD, S_SHF_WR, S_INS, S_RSP, S_FL_CHK, S_FL_RD, S_FL_OUT,
      S_FL_EMPTY
   } state_type;

   typedef struct packed {
      logic [31:0] seq;
      logic [15:0] handle;
      logic [31:0] ts;
      logic        marked;
   } entry_type;

   typedef struct packed {
      logic        idle;
      logic        tick;
      logic        restart;
      logic        fl_init;
      logic        srch_init;
      logic        rd_en;
      logic        rd_prev;
      logic        cmp;
      logic        idx_inc;
      logic        gate;
      logic        shift_init;
      logic        wr_shift;
      logic        wr_new;
      logic        load;
      rsp_sel_type rsp_sel;
      status_type  rsp_status;
      logic        fl_done;
   } cmd_type;

   typedef struct packed {
      logic     req_valid;
      func_type func;
      logic     seq_valid;
      logic     idx_at_count;
      logic     eq;
      logic     gt;
      logic     store;
      logic     full;
      logic     idx_at_pos;
      logic     out_free;
      logic     count_zero;
      logic     fl_last;
   } stat_type;

endpackage

// ===== rtl/rvsg_req_if.sv =====
// ---------------------------------------------------------------------------
// rvsg_req_if
// request channel: packet descriptors and commands into the block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rvsg_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [31:0] ext_seq;
   logic        seq_valid;
   logic        seq_restart;
   logic        marked;
   logic [15:0] payload_word0;
   logic [15:0] payload_word2;
   logic [31:0] rtp_timestamp;
   logic [15:0] packet_handle;

   modport source (output valid, func, ext_seq, seq_valid, seq_restart, marked,
                   payload_word0, payload_word2, rtp_timestamp, packet_handle,
                   input ready);
   modport sink (input valid, func, ext_seq, seq_valid, seq_restart, marked,
                 payload_word0, payload_word2, rtp_timestamp, packet_handle,
                 output ready);
endinterface

// ===== rtl/rvsg_rsp_if.sv =====
// ---------------------------------------------------------------------------
// rvsg_rsp_if
// response channel: packet status and flushed descriptors out of the block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rvsg_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [1:0]  status;
   logic [15:0] out_handle;
   logic [31:0] out_seq;
   logic [31:0] out_timestamp;
   logic        frame_end;
   logic        last;
   logic        empty_res;
   logic        ignored_valid;
   logic [31:0] first_ignored_timestamp;

   modport source (output valid, kind, status, out_handle, out_seq, out_timestamp,
                   frame_end, last, empty_res, ignored_valid,
                   first_ignored_timestamp, input ready);
   modport sink (input valid, kind, status, out_handle, out_seq, out_timestamp,
                 frame_end, last, empty_res, ignored_valid,
                 first_ignored_timestamp, output ready);
endinterface

// ===== rtl/rvsg_ram.sv =====
// ---------------------------------------------------------------------------
// rvsg_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rvsg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rvsg_ctrl.sv =====
// ---------------------------------------------------------------------------
// rvsg_ctrl
// sequencer for search, start gate, insert shift and flush
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rvsg_ctrl import rvsg_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  stat_type st,
   output cmd_type  cmd
);

   state_type  state_ff, state_in;
   status_type code_ff, code_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= ST_ACCEPTED;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (st.req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            unique case (st.func)
               FUNC_TICK, FUNC_RESTART: state_in = S_IDLE;
               FUNC_FLUSH:              state_in = S_FL_CHK;
               FUNC_PACKET: begin
                  if (!st.seq_valid) begin
                     code_in  = ST_INVALID;
                     state_in = S_RSP;
                  end else begin
                     state_in = S_SRCH_CHK;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_SRCH_CHK: state_in = st.idx_at_count ? S_GATE : S_SRCH_RD;
         S_SRCH_RD:  state_in = S_SRCH_CMP;
         S_SRCH_CMP: begin
            priority if (st.eq) begin
               code_in  = ST_DUPLICATE;
               state_in = S_RSP;
            end else if (st.gt) begin
               state_in = S_GATE;
            end else begin
               state_in = S_SRCH_CHK;
            end
         end
         S_GATE: state_in = S_STORE_CHK;
         S_STORE_CHK: begin
            priority if (!st.store) begin
               code_in  = ST_ACCEPTED;
               state_in = S_RSP;
            end else if (st.full) begin
               code_in  = ST_FULL;
               state_in = S_RSP;
            end else begin
               state_in = S_SHF_CHK;
            end
         end
         S_SHF_CHK: state_in = st.idx_at_pos ? S_INS : S_SHF_RD;
         S_SHF_RD:  state_in = S_SHF_WR;
         S_SHF_WR:  state_in = S_SHF_CHK;
         S_INS: begin
            code_in  = ST_ACCEPTED;
            state_in = S_RSP;
         end
         S_RSP: begin
            if (st.out_free) state_in = S_IDLE;
         end
         S_FL_CHK:   state_in = st.count_zero ? S_FL_EMPTY : S_FL_RD;
         S_FL_EMPTY: begin
            if (st.out_free) state_in = S_IDLE;
         end
         S_FL_RD: state_in = S_FL_OUT;
         S_FL_OUT: begin
            if (st.out_free) state_in = st.fl_last ? S_IDLE : S_FL_RD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd            = '0;
      cmd.rsp_sel    = SEL_STATUS;
      cmd.rsp_status = code_ff;
      unique case (state_ff)
         S_IDLE: cmd.idle = 1'b1;
         S_DECODE: begin
            unique case (st.func)
               FUNC_TICK:    cmd.tick = 1'b1;
               FUNC_RESTART: cmd.restart = 1'b1;
               FUNC_FLUSH:   cmd.fl_init = 1'b1;
               FUNC_PACKET:  cmd.srch_init = st.seq_valid;
               default:      cmd.tick = 1'b0;
            endcase
         end
         S_SRCH_RD: cmd.rd_en = 1'b1;
         S_SRCH_CMP: begin
            cmd.cmp     = 1'b1;
            cmd.idx_inc = !st.eq && !st.gt;
         end
         S_GATE: cmd.gate = 1'b1;
         S_STORE_CHK: cmd.shift_init = st.store && !st.full;
         S_SHF_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_prev = 1'b1;
         end
         S_SHF_WR: cmd.wr_shift = 1'b1;
         S_INS:    cmd.wr_new = 1'b1;
         S_RSP:    cmd.load = st.out_free;
         S_FL_EMPTY: begin
            cmd.load    = st.out_free;
            cmd.rsp_sel = SEL_EMPTY;
         end
         S_FL_RD: cmd.rd_en = 1'b1;
         S_FL_OUT: begin
            cmd.load    = st.out_free;
            cmd.rsp_sel = SEL_FLUSH;
            cmd.fl_done = st.out_free && st.fl_last;
            cmd.idx_inc = st.out_free && !st.fl_last;
         end
         default: cmd.idle = 1'b0;
      endcase
   end

endmodule

// ===== rtl/rvsg_dp.sv =====
// ---------------------------------------------------------------------------
// rvsg_dp
// datapath: circular sorted store, gate state, counters and output register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rtp_video_reorder_start_gate_core_defines.svh"

module rvsg_dp import rvsg_pkg::*; #(
   parameter int BUFFER_DEPTH = BufferDepthDefault
) (
   input  logic          clock,
   input  logic          reset,
   rvsg_req_if.sink      req,
   rvsg_rsp_if.source    rsp,
   input  logic          csr_we,
   input  logic [31:0]   csr_wdata,
   input  cmd_type       cmd,
   output stat_type      st
);

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int CW = $clog2(BUFFER_DEPTH + 1);
   localparam int SW = CW + 1;

   // captured item
   logic [1:0]  func_ff;
   logic [31:0] seq_ff;
   logic        seq_valid_ff, seq_restart_ff, marked_ff;
   logic [15:0] w0_ff, w2_ff, handle_ff;
   logic [31:0] ts_ff;

   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in, idx_ff, idx_in, pos_ff, pos_in;
   logic          start_ff, start_in, wait_ff, wait_in, store_ff, store_in;
   logic          ign_flag_ff, ign_flag_in;
   logic [31:0]   ign_ts_ff, ign_ts_in, ts0_ff, ts0_in;
   logic [31:0]   elapsed_ff, elapsed_in, max_wait_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          r_kind_ff, r_fend_ff, r_last_ff, r_empty_ff;
   logic [1:0]    r_status_ff;
   logic [15:0]   r_handle_ff;
   logic [31:0]   r_seq_ff, r_ts_ff;
   logic          r_ign_flag_ff;
   logic [31:0]   r_ign_ts_ff;

   entry_type     rd_entry, wr_entry;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          wr_en, accept, intra, idx_is_end, fl_last;

   function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base,
                                          input logic [CW-1:0] off);
      logic [SW-1:0] s;
      s = SW'(base) + SW'(off);
      if (s >= SW'(BUFFER_DEPTH)) s = s - SW'(BUFFER_DEPTH);
      return s[AW-1:0];
   endfunction

   assign accept    = req.valid && cmd.idle;
   assign req.ready = cmd.idle;

   // mode a picture type bit, or mode b/c intra flag in word 2
   assign intra = ((w0_ff & ModeBcBit) == 16'h0) ? ((w0_ff & PictBit) == 16'h0)
                                                 : ((w2_ff & ModeBcBit) == 16'h0);

   assign idx_is_end = (idx_ff + CW'(1)) == count_ff;
   assign fl_last    = idx_is_end || (32'(idx_ff) == 32'(MaxResults - 1));

   assign rd_addr  = wrap(head_ff, cmd.rd_prev ? (idx_ff - CW'(1)) : idx_ff);
   assign wr_en    = cmd.wr_shift || cmd.wr_new;
   assign wr_addr  = wrap(head_ff, cmd.wr_shift ? idx_ff : pos_ff);
   assign wr_entry = cmd.wr_shift ? rd_entry
                                  : '{seq: seq_ff, handle: handle_ff, ts: ts_ff,
                                      marked: marked_ff};

   rvsg_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (BUFFER_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   always_comb begin
      st              = '0;
      st.req_valid    = req.valid;
      st.func         = func_type'(func_ff);
      st.seq_valid    = seq_valid_ff;
      st.idx_at_count = idx_ff == count_ff;
      st.eq           = rd_entry.seq == seq_ff;
      st.gt           = rd_entry.seq > seq_ff;
      st.store        = store_ff;
      st.full         = count_ff >= CW'(BUFFER_DEPTH);
      st.idx_at_pos   = idx_ff == pos_ff;
      st.out_free     = !rsp_valid_ff || rsp.ready;
      st.count_zero   = count_ff == '0;
      st.fl_last      = fl_last;
   end

   always_comb begin
      head_in     = head_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      pos_in      = pos_ff;
      start_in    = start_ff;
      wait_in     = wait_ff;
      store_in    = store_ff;
      ign_flag_in = ign_flag_ff;
      ign_ts_in   = ign_ts_ff;
      ts0_in      = ts0_ff;
      elapsed_in  = elapsed_ff;

      if (cmd.tick && (elapsed_ff != '1)) elapsed_in = elapsed_ff + 32'd1;
      if (cmd.restart) begin
         count_in    = '0;
         start_in    = 1'b0;
         wait_in     = 1'b0;
         ign_flag_in = 1'b0;
         ign_ts_in   = '0;
         elapsed_in  = '0;
      end
      if (cmd.fl_init) begin
         if (!start_ff) count_in = '0;
         idx_in = '0;
      end
      if (cmd.srch_init) begin
         idx_in = '0;
         if (seq_restart_ff) begin
            count_in = '0;
            start_in = 1'b0;
            pos_in   = '0;
         end else begin
            pos_in = count_ff;
         end
      end
      if (cmd.cmp) begin
         if (idx_ff == '0) ts0_in = rd_entry.ts;
         if (st.gt) pos_in = idx_ff;
      end
      if (cmd.idx_inc) idx_in = idx_ff + CW'(1);
      if (cmd.gate) begin
         store_in = 1'b1;
         if (!start_ff) begin
            if (intra || (wait_ff && marked_ff)) begin
               if (!intra) begin
                  wait_in  = 1'b0;
                  store_in = 1'b0;
               end
               // recording starts: older entries are erased
               start_in = 1'b1;
               if (count_ff != '0) begin
                  if (!ign_flag_ff) begin
                     ign_flag_in = 1'b1;
                     ign_ts_in   = ts0_ff;
                  end
                  head_in  = wrap(head_ff, pos_ff);
                  count_in = count_ff - pos_ff;
                  pos_in   = '0;
               end
            end else if (elapsed_ff > max_wait_ff) begin
               wait_in = 1'b1;
            end
         end
      end
      if (cmd.shift_init) idx_in = count_ff;
      if (cmd.wr_shift) idx_in = idx_ff - CW'(1);
      if (cmd.wr_new) count_in = count_ff + CW'(1);
      if (cmd.fl_done) begin
         head_in  = wrap(head_ff, idx_ff + CW'(1));
         count_in = count_ff - (idx_ff + CW'(1));
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;
      if (cmd.load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         pos_ff       <= '0;
         start_ff     <= 1'b0;
         wait_ff      <= 1'b0;
         store_ff     <= 1'b0;
         ign_flag_ff  <= 1'b0;
         ign_ts_ff    <= '0;
         elapsed_ff   <= '0;
         max_wait_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         pos_ff       <= pos_in;
         start_ff     <= start_in;
         wait_ff      <= wait_in;
         store_ff     <= store_in;
         ign_flag_ff  <= ign_flag_in;
         ign_ts_ff    <= ign_ts_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) max_wait_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      ts0_ff <= ts0_in;
      if (accept) begin
         func_ff        <= req.func;
         seq_ff         <= req.ext_seq;
         seq_valid_ff   <= req.seq_valid;
         seq_restart_ff <= req.seq_restart;
         marked_ff      <= req.marked;
         w0_ff          <= req.payload_word0;
         w2_ff          <= req.payload_word2;
         ts_ff          <= req.rtp_timestamp;
         handle_ff      <= req.packet_handle;
      end
      if (cmd.load) begin
         r_kind_ff     <= cmd.rsp_sel != SEL_STATUS;
         r_status_ff   <= (cmd.rsp_sel == SEL_STATUS) ? cmd.rsp_status : ST_ACCEPTED;
         r_empty_ff    <= cmd.rsp_sel == SEL_EMPTY;
         // gate flags as they stand for this result, held while it waits
         r_ign_flag_ff <= ign_flag_ff;
         r_ign_ts_ff   <= ign_flag_ff ? ign_ts_ff : 32'd0;
         if (cmd.rsp_sel == SEL_FLUSH) begin
            r_handle_ff <= rd_entry.handle;
            r_seq_ff    <= rd_entry.seq;
            r_ts_ff     <= rd_entry.ts;
            r_fend_ff   <= rd_entry.marked || idx_is_end;
            r_last_ff   <= fl_last;
         end else begin
            r_handle_ff <= '0;
            r_seq_ff    <= '0;
            r_ts_ff     <= '0;
            r_fend_ff   <= 1'b0;
            r_last_ff   <= 1'b1;
         end
      end
   end

   assign rsp.valid                   = rsp_valid_ff;
   assign rsp.kind                    = r_kind_ff;
   assign rsp.status                  = r_status_ff;
   assign rsp.out_handle              = r_handle_ff;
   assign rsp.out_seq                 = r_seq_ff;
   assign rsp.out_timestamp           = r_ts_ff;
   assign rsp.frame_end               = r_fend_ff;
   assign rsp.last                    = r_last_ff;
   assign rsp.empty_res               = r_empty_ff;
   assign rsp.ignored_valid           = r_ign_flag_ff;
   assign rsp.first_ignored_timestamp = r_ign_ts_ff;

   `RVSG_ASSERT_ALWAYS(a_count_bound, count_ff <= CW'(BUFFER_DEPTH), "entry count above depth")
   `RVSG_ASSERT_ALWAYS(a_ign_ts_clear, ign_flag_ff || (ign_ts_ff == '0), "ignored ts without flag")
   `RVSG_ASSERT_ALWAYS(a_insert_room, !cmd.wr_new || (count_ff < CW'(BUFFER_DEPTH)), "insert into full store")
   `RVSG_ASSERT_NEXT(a_load_valid, cmd.load, rsp_valid_ff, "loaded result not presented")

endmodule

// ===== rtl/rtp_video_reorder_start_gate_core.sv =====
// ---------------------------------------------------------------------------
// rtp_video_reorder_start_gate_core
// sorted rtp descriptor store with duplicate drop and i-frame start gate
// ---------------------------------------------------------------------------
//  port       dir    content
//  req_chan   sink   func, sequence, marker, payload header words, ts, handle
//  rsp_chan   source packet status or one flushed descriptor per item
//  csr_*      in     max_wait_ticks write
//
//  tick/restart: idle, decode, back to idle. a packet searches the stored entries and,
//  when it lands ahead of stored entries, shifts them up to make room; it ends early on a
//  duplicate, bad sequence or full store; every entry searched or shifted uses one ram.
//  flush: emits one item at a time, each held while rsp stalls.
//  reset clears counts and flags; the store needs no clearing pass.
//  a waiting result holds in the output register while the next item enters.
`timescale 1ns / 1ps

module rtp_video_reorder_start_gate_core import rvsg_pkg::*; #(
   parameter int BUFFER_DEPTH = BufferDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   rvsg_req_if.sink    req_chan,
   rvsg_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);

   cmd_type  cmd;
   stat_type st;

   rvsg_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .st    (st),
      .cmd   (cmd)
   );

   rvsg_dp #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .st        (st)
   );

endmodule
